[hw/rtl/pdcr_pkg.sv]
// Shared types and constants for the pointer-driven color ramp.
// Used by the top level; depends on nothing.
package pdcr_pkg;

    // Fixed field widths.
    localparam int COORD_W = 12;
    localparam int CCNT_W = 9;
    localparam int IDX_W = 8;
    localparam int BTN_W = 2;
    localparam int LVL_W = 16;
    localparam int FRAC_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Default for the largest ramp length.
    localparam int MAX_COLORS_DEF = 256;

    // Divider widths: scaled coordinate numerators and the ramp product.
    localparam int QA_W = COORD_W + FRAC_W;
    localparam int PROD_W = QA_W + IDX_W;
    localparam int ICPT_W = FRAC_W + 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_COLORS = 3'd2,
        CFG_INVERT = 3'd3,
        CFG_RGB = 3'd4
    } cfg_idx_t;

    // Button codes.
    localparam logic [BTN_W-1:0] BTN_RED = 2'd0;
    localparam logic [BTN_W-1:0] BTN_GREEN = 2'd1;
    localparam logic [BTN_W-1:0] BTN_BLUE = 2'd2;
    localparam logic [BTN_W-1:0] BTN_NONE = 2'd3;

    // Data riding alongside the coordinate dividers.
    typedef struct packed {
        logic ok;
        logic neg;
        logic [IDX_W-1:0] idx;
        logic [BTN_W-1:0] button;
    } side_a_t;

    // Data riding alongside the ramp divider.
    typedef struct packed {
        logic ok;
        logic [IDX_W-1:0] idx;
        logic [BTN_W-1:0] button;
        logic signed [ICPT_W-1:0] icpt;
    } side_c_t;

endpackage

[hw/rtl/pdcr_div_cell.sv]
// One restoring division step: one quotient bit per cell.
// Depends on nothing; instantiated by pdcr_div_chain.
module pdcr_div_cell #(
    parameter int NW = 28,
    parameter int DW = 12,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [DW-1:0] out_div,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    // Shift in the next numerator bit and subtract where the divisor fits.
    always_comb
    begin
        trial = {in_rem, in_num[NW-1]};
        diff = trial - {1'b0, in_div};
        fits = (trial >= {1'b0, in_div});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        num_next = {in_num[NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            div_reg <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem = rem_reg;
    assign out_num = num_reg;
    assign out_div = div_reg;
    assign out_side = side_reg;

endmodule

[hw/rtl/pdcr_div_chain.sv]
// Pipelined unsigned divider built as a row of division cells.
// Depends on pdcr_div_cell; the quotient leaves the last cell in the row.
module pdcr_div_chain #(
    parameter int NW = 28,
    parameter int DW = 12,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          v_w    [NW+1];
    logic [DW-1:0] rem_w  [NW+1];
    logic [NW-1:0] num_w  [NW+1];
    logic [DW-1:0] div_w  [NW+1];
    logic [SW-1:0] side_w [NW+1];

    assign v_w[0] = in_valid;
    assign rem_w[0] = '0;
    assign num_w[0] = in_num;
    assign div_w[0] = in_div;
    assign side_w[0] = in_side;

    // Each cell takes its neighbor's partial result every cycle that en is high.
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        pdcr_div_cell #(
            .NW(NW),
            .DW(DW),
            .SW(SW)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .en(en),
            .in_valid(v_w[i]),
            .in_rem(rem_w[i]),
            .in_num(num_w[i]),
            .in_div(div_w[i]),
            .in_side(side_w[i]),
            .out_valid(v_w[i+1]),
            .out_rem(rem_w[i+1]),
            .out_num(num_w[i+1]),
            .out_div(div_w[i+1]),
            .out_side(side_w[i+1])
        );
    end

    assign out_valid = v_w[NW];
    assign out_quo = num_w[NW];
    assign out_side = side_w[NW];

endmodule

[hw/rtl/pointer_driven_color_ramp.sv]
// Top level of the pointer-driven color ramp.
// Depends on pdcr_pkg and pdcr_div_chain.
//
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  s_tdata: x, y, index; s_tuser: button
// m_       out        m_tvalid/m_tready  m_tdata: index, intensity; m_tuser: flags
// cfg_     in         cfg_we             cfg_index, cfg_data
//
// One word is accepted every cycle that no output word is stalled. The pipeline
// holds 28 division cells for intercept and slope, one multiply stage, 36 cells
// for the ramp division, and the output register. Reset clears the valid bits
// and loads the configuration defaults. A stalled output word freezes the whole
// pipeline, so s_tready follows m_tready whenever the output register holds a word.
module pointer_driven_color_ramp #(
    parameter int MAX_COLORS = pdcr_pkg::MAX_COLORS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // pointer_x, pointer_y, entry_index
    input  logic [1:0]  s_tuser,  // button
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // out_index, intensity
    output logic [3:0]  m_tuser,  // accepted, write_red, write_green, write_blue
    input  logic        cfg_we,
    input  logic [pdcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdcr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = pdcr_pkg::COORD_W;
    localparam int QW = pdcr_pkg::QA_W;
    localparam int PW = pdcr_pkg::PROD_W;
    localparam int KW = pdcr_pkg::CCNT_W;
    localparam int IW = pdcr_pkg::ICPT_W;
    localparam int LW = pdcr_pkg::LVL_W;
    localparam int SUM_W = PW + 2;

    // Configuration registers.
    logic [CW-1:0] width_reg;
    logic [CW-1:0] height_reg;
    logic [KW-1:0] colors_reg;
    logic          invert_reg;
    logic          rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 12'd512;
            height_reg <= 12'd512;
            colors_reg <= 9'd256;
            invert_reg <= 1'b0;
            rgb_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pdcr_pkg::CFG_WIDTH:  width_reg <= cfg_data;
                pdcr_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                pdcr_pkg::CFG_COLORS: colors_reg <= cfg_data[KW-1:0];
                pdcr_pkg::CFG_INVERT: invert_reg <= cfg_data[0];
                pdcr_pkg::CFG_RGB:    rgb_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Input decode: window check, intercept numerator magnitude and sign, slope numerator.
    logic [CW-1:0] px, py;
    logic [7:0]    pidx;
    logic [12:0]   colors;
    logic          ok_in;
    logic [13:0]   dx;
    logic [13:0]   dx_mag;
    logic [QW-1:0] num_a, num_b;
    logic [CW-1:0] h_minus_y;
    pdcr_pkg::side_a_t side_a_in;

    always_comb
    begin
        px = s_tdata[11:0];
        py = s_tdata[23:12];
        pidx = s_tdata[31:24];
        colors = ({4'b0, colors_reg} > 13'(MAX_COLORS)) ? 13'(MAX_COLORS)
                                                         : {4'b0, colors_reg};
        ok_in = (py != '0) && (py <= height_reg)
              && ({1'b0, px} + 13'd2 < {1'b0, width_reg})
              && ({5'b0, pidx} < colors);
        dx = {1'b0, px, 1'b0} - {2'b0, width_reg};
        dx_mag = dx[13] ? (14'd0 - dx) : dx;
        h_minus_y = height_reg - py;
        num_a = {dx_mag[CW-1:0], {pdcr_pkg::FRAC_W{1'b0}}};
        num_b = {h_minus_y, {pdcr_pkg::FRAC_W{1'b0}}};
        side_a_in.ok = ok_in;
        side_a_in.neg = dx[13];
        side_a_in.idx = pidx;
        side_a_in.button = s_tuser;
    end

    // Intercept and slope dividers run side by side.
    logic          va_out, vb_out;
    logic [QW-1:0] qa, qb;
    logic [$bits(pdcr_pkg::side_a_t)-1:0] side_a_raw;
    logic          side_b_raw;
    pdcr_pkg::side_a_t side_a_out;

    pdcr_div_chain #(.NW(QW), .DW(CW), .SW($bits(pdcr_pkg::side_a_t))) u_div_icpt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_tvalid), .in_num(num_a), .in_div(width_reg), .in_side(side_a_in),
        .out_valid(va_out), .out_quo(qa), .out_side(side_a_raw)
    );

    pdcr_div_chain #(.NW(QW), .DW(CW), .SW(1)) u_div_slope (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_tvalid), .in_num(num_b), .in_div(py), .in_side(ok_in),
        .out_valid(vb_out), .out_quo(qb), .out_side(side_b_raw)
    );

    assign side_a_out = side_a_raw;

    // Multiply stage: slope times index, intercept sign applied.
    logic                 v1_reg;
    logic [PW-1:0]        prod_reg, prod_next;
    pdcr_pkg::side_c_t    side1_reg, side1_next;
    logic [IW-1:0]        icpt_mag;

    always_comb
    begin
        prod_next = PW'(qb) * PW'(side_a_out.idx);
        icpt_mag = {1'b0, qa[IW-2:0]};
        side1_next.ok = side_a_out.ok && side_b_raw;
        side1_next.idx = side_a_out.idx;
        side1_next.button = side_a_out.button;
        side1_next.icpt = side_a_out.neg ? $signed(IW'(0) - icpt_mag) : $signed(icpt_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= va_out && vb_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            side1_reg <= side1_next;
        end
    end

    // Ramp divisor: entry count less one, at least one.
    logic [KW-1:0] divisor;
    always_comb
    begin
        if (colors <= 13'd2)
        begin
            divisor = KW'(1);
        end
        else
        begin
            divisor = KW'(colors - 13'd1);
        end
    end

    logic          vc_out;
    logic [PW-1:0] qc;
    logic [$bits(pdcr_pkg::side_c_t)-1:0] side_c_raw;
    pdcr_pkg::side_c_t side_c_out;

    pdcr_div_chain #(.NW(PW), .DW(KW), .SW($bits(pdcr_pkg::side_c_t))) u_div_ramp (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1_reg), .in_num(prod_reg), .in_div(divisor), .in_side(side1_reg),
        .out_valid(vc_out), .out_quo(qc), .out_side(side_c_raw)
    );

    assign side_c_out = side_c_raw;

    // Final sum, clamp, invert, channel selection and zeroing of rejected positions.
    logic signed [SUM_W-1:0] level;
    logic [LW-1:0]           lvl;
    logic [LW-1:0]           data_next;
    logic [2:0]              wr_next;
    logic [LW-1:0]           data_reg;
    logic [2:0]              wr_reg;
    logic                    acc_reg;
    logic [7:0]              idx_reg;

    always_comb
    begin
        level = $signed({2'b0, qc}) + SUM_W'(side_c_out.icpt);
        if (level < 0)
        begin
            lvl = '0;
        end
        else if (level > $signed(SUM_W'(65535)))
        begin
            lvl = '1;
        end
        else
        begin
            lvl = level[LW-1:0];
        end
        data_next = invert_reg ? ~lvl : lvl;
        if (rgb_reg)
        begin
            wr_next = {side_c_out.button == pdcr_pkg::BTN_BLUE,
                       side_c_out.button == pdcr_pkg::BTN_GREEN,
                       side_c_out.button == pdcr_pkg::BTN_RED};
        end
        else
        begin
            wr_next = 3'b111;
        end
        if (!side_c_out.ok)
        begin
            data_next = '0;
            wr_next = 3'b000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vc_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            wr_reg <= wr_next;
            acc_reg <= side_c_out.ok;
            idx_reg <= side_c_out.idx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {data_reg, idx_reg};
    assign m_tuser = {wr_reg, acc_reg};

endmodule

[hw/rtl/pdcr_checker.sv]
// Port-level checks for the pointer-driven color ramp, bound to the top level.
// Depends on pointer_driven_color_ramp's port list only.
module pdcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // A stalled output word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // A rejected position carries no intensity and no writes.
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tuser[3:1] == 3'b000 && m_tdata[23:8] == 16'd0)
        else $error("rejected word carries data");

    // Writes go to at most one channel or to all three.
    a_chan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones(m_tuser[3:1]) <= 1 || m_tuser[3:1] == 3'b111)
        else $error("bad channel write pattern");

    // The input is held off only by a stalled output word.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled without output stall");

endmodule

bind pointer_driven_color_ramp pdcr_checker u_pdcr_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);
